### hdl/ikn_pkg.sv
package ikn_pkg;

  // Fixed-point constants (angles Q3.12, lengths Q7.8).
  localparam int Q_PI      = 12868;
  localparam int Q_HALF_PI = 6434;
  localparam int ONE_CM    = 256;
  localparam int COS_SQ    = 268435456;

  // Register map indexes.
  localparam logic [2:0] REG_BASE_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_UPPER_ARM    = 3'd1;
  localparam logic [2:0] REG_FOREARM      = 3'd2;
  localparam logic [2:0] REG_WRIST        = 3'd3;
  localparam logic [2:0] REG_TOOL_OFFSET  = 3'd4;
  localparam logic [2:0] REG_HEIGHT_LIMIT = 3'd5;
  localparam logic [2:0] REG_REACH_LIMIT  = 3'd6;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Square root unit: one root bit per stage.
  localparam int SQRT_IN_W  = 34;
  localparam int SQRT_OUT_W = 17;
  localparam int SQRT_LAT   = SQRT_OUT_W;

  // Ratio divider: one input stage and one quotient bit per stage.
  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_Q_W   = 14;
  localparam int DIV_LAT   = DIV_Q_W + 1;

  // Vectoring CORDIC: one fold stage and one rotation per stage.
  localparam int CORDIC_IN_W  = 18;
  localparam int CORDIC_W     = 42;
  localparam int CORDIC_SCALE = 20;
  localparam int CORDIC_STEPS = 13;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

  // Total latency of the back end, from queue head to result strobe.
  localparam int BACK_LAT = SQRT_LAT + 1 + DIV_LAT + 1 + SQRT_LAT + CORDIC_LAT + 1;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] rotate_angle;
    logic signed [15:0] grip_angle;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] base_angle;
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
    logic signed [15:0] wrist_angle;
    logic signed [15:0] rotate_out;
    logic signed [15:0] grip_out;
    logic               rejected;
  } res_t;

  typedef struct packed {
    logic [14:0] base_height;
    logic [14:0] upper_arm_length;
    logic [14:0] forearm_length;
    logic [14:0] wrist_length;
    logic [14:0] tool_offset;
    logic [14:0] height_limit;
    logic [14:0] reach_limit;
  } cfg_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic               rejected;
    logic               on_axis;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [17:0] w;
    logic [31:0]        r2;
    logic [33:0]        m2;
    logic signed [15:0] tilt;
    logic signed [15:0] rotate;
    logic signed [15:0] grip;
  } job_t;

  // Arctangent of 2^-i in Q3.12.
  function automatic logic signed [15:0] atan_entry(input int idx);
    logic signed [15:0] v;
    case (idx)
      0:       v = 16'sd3217;
      1:       v = 16'sd1899;
      2:       v = 16'sd1003;
      3:       v = 16'sd509;
      4:       v = 16'sd256;
      5:       v = 16'sd128;
      6:       v = 16'sd64;
      7:       v = 16'sd32;
      8:       v = 16'sd16;
      9:       v = 16'sd8;
      10:      v = 16'sd4;
      11:      v = 16'sd2;
      12:      v = 16'sd1;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Clamp a wide angle to the signed 16-bit output range.
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### hdl/arm_inverse_kinematics_top.sv
// Arm inverse kinematics engine. A target word (x, y, z, tilt, rotate, grip) is
// taken at each clock edge where start is high and busy is low, and one word of six
// joint angles with a reject flag comes back on result_o, marked by done_o for a
// single cycle, after front, queue and back end. A new target may be given every cycle;
// the back end is a fixed pipeline of square root, divider and CORDIC stages that never
// stalls, so busy stays low in steady use. Results cannot be held off: the receiver must
// take each word in the cycle that done_o marks. Link lengths and limits are written via
// APB, by the user only while no target is in flight; the block does not enforce it.
module arm_inverse_kinematics_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ikn_pkg::cmd_t cmd_i,
  output logic          done_o,
  output ikn_pkg::res_t result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  ikn_pkg::cfg_t cfg_q;
  ikn_pkg::job_t front_job, queue_job;
  logic          accept, push, pop;
  logic          wr_en;
  logic [14:0]   wval, wlen;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[14:0];
  assign wlen   = (wval == '0) ? 15'd1 : wval;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_height      <= 15'd0;
      cfg_q.upper_arm_length <= 15'd1;
      cfg_q.forearm_length   <= 15'd1;
      cfg_q.wrist_length     <= 15'd0;
      cfg_q.tool_offset      <= 15'd0;
      cfg_q.height_limit     <= 15'd3840;
      cfg_q.reach_limit      <= 15'd6400;
    end else if (wr_en) begin
      case (paddr[4:2])
        ikn_pkg::REG_BASE_HEIGHT:  cfg_q.base_height      <= wval;
        ikn_pkg::REG_UPPER_ARM:    cfg_q.upper_arm_length <= wlen;
        ikn_pkg::REG_FOREARM:      cfg_q.forearm_length   <= wlen;
        ikn_pkg::REG_WRIST:        cfg_q.wrist_length     <= wval;
        ikn_pkg::REG_TOOL_OFFSET:  cfg_q.tool_offset      <= wval;
        ikn_pkg::REG_HEIGHT_LIMIT: cfg_q.height_limit     <= wval;
        ikn_pkg::REG_REACH_LIMIT:  cfg_q.reach_limit      <= wval;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[4:2])
      ikn_pkg::REG_BASE_HEIGHT:  prdata = 32'(cfg_q.base_height);
      ikn_pkg::REG_UPPER_ARM:    prdata = 32'(cfg_q.upper_arm_length);
      ikn_pkg::REG_FOREARM:      prdata = 32'(cfg_q.forearm_length);
      ikn_pkg::REG_WRIST:        prdata = 32'(cfg_q.wrist_length);
      ikn_pkg::REG_TOOL_OFFSET:  prdata = 32'(cfg_q.tool_offset);
      ikn_pkg::REG_HEIGHT_LIMIT: prdata = 32'(cfg_q.height_limit);
      ikn_pkg::REG_REACH_LIMIT:  prdata = 32'(cfg_q.reach_limit);
      default:                   prdata = 32'd0;
    endcase
  end

  assign accept = start && !busy;

  ikn_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .accept_i(accept), .cmd_i(cmd_i),
    .cfg_i(cfg_q), .push_o(push), .job_o(front_job)
  );

  ikn_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .job_i(front_job),
    .pop_o(pop), .job_o(queue_job), .busy_o(busy)
  );

  ikn_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .pop_i(pop), .job_i(queue_job),
    .cfg_i(cfg_q), .done_o(done_o), .res_o(result_o)
  );

endmodule

### hdl/ikn_front.sv
module ikn_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  ikn_pkg::cmd_t cmd_i,
  input  ikn_pkg::cfg_t cfg_i,
  output logic          push_o,
  output ikn_pkg::job_t job_o
);

  logic               v1_q, v2_q;
  logic               rej1_q, axis1_q, rej2_q, axis2_q;
  logic signed [15:0] x1_q, y1_q, tilt1_q, rot1_q, grip1_q;
  logic signed [15:0] x2_q, y2_q, tilt2_q, rot2_q, grip2_q;
  logic signed [17:0] w1_q, w2_q;
  logic signed [17:0] w_d;
  logic               rej_d;
  logic signed [31:0] xx_q, yy_q;
  logic signed [35:0] ww_q;
  logic [31:0]        r2;

  // Valid bits of the two front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  // Limit checks and the vertical offset of the wrist.
  always_comb begin
    rej_d = ($signed({cmd_i.target_z[15], cmd_i.target_z}) >=
             $signed({2'b00, cfg_i.height_limit})) ||
            ($signed({cmd_i.target_x[15], cmd_i.target_x}) >=
             $signed({2'b00, cfg_i.reach_limit})) ||
            ($signed({cmd_i.target_y[15], cmd_i.target_y}) >=
             $signed({2'b00, cfg_i.reach_limit}));
    w_d = $signed({3'b000, cfg_i.wrist_length}) + $signed({3'b000, cfg_i.tool_offset})
        + 18'(cmd_i.target_z) - $signed({3'b000, cfg_i.base_height});
  end

  // Stage one: classify the target.
  always_ff @(posedge clk_i) begin
    rej1_q  <= rej_d;
    axis1_q <= (cmd_i.target_x == 16'sd0) && (cmd_i.target_y == 16'sd0);
    x1_q    <= cmd_i.target_x;
    y1_q    <= cmd_i.target_y;
    w1_q    <= w_d;
    tilt1_q <= cmd_i.tilt_angle;
    rot1_q  <= cmd_i.rotate_angle;
    grip1_q <= cmd_i.grip_angle;
  end

  // Stage two: squares of the planar and vertical distances.
  always_ff @(posedge clk_i) begin
    rej2_q  <= rej1_q;
    axis2_q <= axis1_q;
    x2_q    <= x1_q;
    y2_q    <= y1_q;
    w2_q    <= w1_q;
    tilt2_q <= tilt1_q;
    rot2_q  <= rot1_q;
    grip2_q <= grip1_q;
    xx_q    <= 32'(x1_q) * 32'(x1_q);
    yy_q    <= 32'(y1_q) * 32'(y1_q);
    ww_q    <= 36'(w1_q) * 36'(w1_q);
  end

  // Sum the squares on the way into the queue.
  assign r2     = xx_q[31:0] + yy_q[31:0];
  assign push_o = v2_q;

  always_comb begin
    job_o.rejected = rej2_q;
    job_o.on_axis  = axis2_q;
    job_o.x        = x2_q;
    job_o.y        = y2_q;
    job_o.w        = w2_q;
    job_o.r2       = r2;
    job_o.m2       = 34'(r2) + ww_q[33:0];
    job_o.tilt     = tilt2_q;
    job_o.rotate   = rot2_q;
    job_o.grip     = grip2_q;
  end

endmodule

### hdl/ikn_queue.sv
module ikn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ikn_pkg::job_t job_i,
  output logic          pop_o,
  output ikn_pkg::job_t job_o,
  output logic          busy_o
);

  ikn_pkg::job_t               mem_q [ikn_pkg::QUEUE_DEPTH];
  logic [ikn_pkg::QUEUE_AW-1:0] wr_q, rd_q;
  logic [ikn_pkg::QUEUE_AW:0]   cnt_q;

  // The back end takes a word whenever one is waiting.
  assign pop_o  = (cnt_q != '0);
  assign job_o  = mem_q[rd_q];
  // Leave room for the words still in the front stages.
  assign busy_o = (cnt_q >= (ikn_pkg::QUEUE_AW + 1)'(ikn_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_o) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_o) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_o) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/ikn_sqrt.sv
module ikn_sqrt (
  input  logic                           clk_i,
  input  logic [ikn_pkg::SQRT_IN_W-1:0]  rad_i,
  output logic [ikn_pkg::SQRT_OUT_W-1:0] root_o
);

  localparam int RW = ikn_pkg::SQRT_IN_W + 1;
  localparam int QW = ikn_pkg::SQRT_OUT_W;

  logic [RW-1:0] rem_s [QW+1];
  logic [QW-1:0] q_s   [QW+1];

  assign rem_s[0] = RW'(rad_i);
  assign q_s[0]   = '0;

  // Each stage decides one root bit, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [RW-1:0] term;
    logic          ge;
    assign term = (RW'(q_s[k]) << (I + 1)) | (RW'(1) << (2 * I));
    assign ge   = (rem_s[k] >= term);
    always_ff @(posedge clk_i) begin
      rem_s[k+1] <= ge ? rem_s[k] - term : rem_s[k];
      q_s[k+1]   <= ge ? (q_s[k] | (QW'(1) << I)) : q_s[k];
    end
  end

  assign root_o = q_s[QW];

endmodule

### hdl/ikn_div.sv
module ikn_div (
  input  logic                                 clk_i,
  input  logic signed [ikn_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [ikn_pkg::DIV_DEN_W-1:0]        den_i,
  output logic [ikn_pkg::DIV_Q_W-1:0]          q_o,
  output logic                                 neg_o,
  output logic                                 sat_o
);

  localparam int MW = ikn_pkg::DIV_NUM_W - 1;
  localparam int DW = ikn_pkg::DIV_DEN_W;
  localparam int QW = ikn_pkg::DIV_Q_W;

  logic [MW-1:0] rem_s [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [QW-1:0] q_s   [QW+1];
  logic          neg_s [QW+1];
  logic          sat_s [QW+1];
  logic [ikn_pkg::DIV_NUM_W-1:0] mag;

  assign mag = num_i[ikn_pkg::DIV_NUM_W-1] ? -num_i : num_i;

  // Input stage: magnitude, sign, and whether the ratio reaches one.
  always_ff @(posedge clk_i) begin
    rem_s[0] <= mag[MW-1:0];
    den_s[0] <= den_i;
    q_s[0]   <= '0;
    neg_s[0] <= num_i[ikn_pkg::DIV_NUM_W-1];
    sat_s[0] <= (mag[MW-1:0] >= MW'(den_i));
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW:0] sh;
    logic        ge;
    assign sh = {rem_s[k], 1'b0};
    assign ge = (sh >= (MW + 1)'(den_s[k]));
    always_ff @(posedge clk_i) begin
      rem_s[k+1] <= ge ? MW'(sh - (MW + 1)'(den_s[k])) : sh[MW-1:0];
      den_s[k+1] <= den_s[k];
      q_s[k+1]   <= {q_s[k][QW-2:0], ge};
      neg_s[k+1] <= neg_s[k];
      sat_s[k+1] <= sat_s[k];
    end
  end

  assign q_o   = q_s[QW];
  assign neg_o = neg_s[QW];
  assign sat_o = sat_s[QW];

endmodule

### hdl/ikn_cordic.sv
module ikn_cordic (
  input  logic                                   clk_i,
  input  logic signed [ikn_pkg::CORDIC_IN_W-1:0] y_i,
  input  logic signed [ikn_pkg::CORDIC_IN_W-1:0] x_i,
  output logic signed [15:0]                     ang_o
);

  localparam int W = ikn_pkg::CORDIC_W;
  localparam int N = ikn_pkg::CORDIC_STEPS;

  logic signed [W-1:0] x_s [N+1];
  logic signed [W-1:0] y_s [N+1];
  logic signed [15:0]  a_s [N+1];
  logic                z_s [N+1];
  logic                neg;
  logic signed [ikn_pkg::CORDIC_IN_W:0] xf, yf;

  // Fold the left half plane onto the right one.
  assign neg = x_i[ikn_pkg::CORDIC_IN_W-1];
  assign xf  = neg ? -(ikn_pkg::CORDIC_IN_W + 1)'(x_i) : (ikn_pkg::CORDIC_IN_W + 1)'(x_i);
  assign yf  = neg ? -(ikn_pkg::CORDIC_IN_W + 1)'(y_i) : (ikn_pkg::CORDIC_IN_W + 1)'(y_i);

  always_ff @(posedge clk_i) begin
    x_s[0] <= W'(xf) <<< ikn_pkg::CORDIC_SCALE;
    y_s[0] <= W'(yf) <<< ikn_pkg::CORDIC_SCALE;
    if (neg) begin
      a_s[0] <= (y_i >= 0) ? 16'(ikn_pkg::Q_PI) : 16'(-ikn_pkg::Q_PI);
    end else begin
      a_s[0] <= 16'sd0;
    end
    z_s[0] <= (x_i == 0) && (y_i == 0);
  end

  // Vectoring rotations toward the positive x axis.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [W-1:0] xs, ys;
    assign xs = x_s[k] >>> k;
    assign ys = y_s[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (y_s[k] > 0) begin
        x_s[k+1] <= x_s[k] + ys;
        y_s[k+1] <= y_s[k] - xs;
        a_s[k+1] <= a_s[k] + ikn_pkg::atan_entry(k);
      end else begin
        x_s[k+1] <= x_s[k] - ys;
        y_s[k+1] <= y_s[k] + xs;
        a_s[k+1] <= a_s[k] - ikn_pkg::atan_entry(k);
      end
      z_s[k+1] <= z_s[k];
    end
  end

  // The origin has angle zero.
  assign ang_o = z_s[N] ? 16'sd0 : a_s[N];

endmodule

### hdl/ikn_back.sv
module ikn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_i,
  input  ikn_pkg::job_t job_i,
  input  ikn_pkg::cfg_t cfg_i,
  output logic          done_o,
  output ikn_pkg::res_t res_o
);

  localparam int SL = ikn_pkg::SQRT_LAT;
  localparam int DL = ikn_pkg::DIV_LAT;
  localparam int CL = ikn_pkg::CORDIC_LAT;

  typedef struct packed {
    logic               rejected;
    logic               on_axis;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [17:0] w;
    logic signed [17:0] reach;
    logic signed [15:0] tilt;
    logic signed [15:0] rotate;
    logic signed [15:0] grip;
  } geo_t;

  typedef struct packed {
    geo_t               geo;
    logic               sat_a;
    logic               neg_a;
    logic               sat_b;
    logic               neg_b;
    logic signed [14:0] c_a;
    logic signed [14:0] c_b;
  } cos_t;

  typedef struct packed {
    logic               rejected;
    logic               on_axis;
    logic signed [15:0] tilt;
    logic signed [15:0] rotate;
    logic signed [15:0] grip;
    logic               sat_a;
    logic               neg_a;
    logic               sat_b;
    logic               neg_b;
  } fin_t;

  logic [ikn_pkg::BACK_LAT-1:0] vld_q;
  ikn_pkg::job_t job_q [SL];
  geo_t          geo_q [DL+1];
  cos_t          cos_q [SL+1];
  fin_t          fin_q [CL];

  logic [29:0] d2sq_q, d3sq_q;
  logic [30:0] d2d3_q;

  logic [ikn_pkg::SQRT_OUT_W-1:0] rt_r2, rt_m2, s_a, s_b;
  ikn_pkg::job_t                  j1;
  geo_t                           geo_d, g3;
  cos_t                           cos_d, c5;
  fin_t                           fin_d, f6;

  logic signed [ikn_pkg::DIV_NUM_W-1:0] num_a_q, num_b_q;
  logic [ikn_pkg::DIV_DEN_W-1:0]        den_a_q, den_b_q;
  logic [ikn_pkg::DIV_Q_W-1:0]          q_a, q_b;
  logic                                 neg_a, neg_b, sat_a, sat_b;
  logic [27:0]                          qsq_a_q, qsq_b_q;
  logic [31:0]                          prod_m;

  logic signed [15:0] ang_base, ang_wr, ang_a, ang_b, acos_a, acos_b;
  logic signed [19:0] th1, th2, th3;
  ikn_pkg::res_t      res_d, res_q;
  logic               done_q;

  // Result strobe follows the fixed latency of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[ikn_pkg::BACK_LAT-2:0], pop_i};
      done_q <= vld_q[ikn_pkg::BACK_LAT-2];
    end
  end

  // Link length products depend on configuration only.
  always_ff @(posedge clk_i) begin
    d2sq_q <= 30'(cfg_i.upper_arm_length) * 30'(cfg_i.upper_arm_length);
    d3sq_q <= 30'(cfg_i.forearm_length) * 30'(cfg_i.forearm_length);
    d2d3_q <= {1'b0, 30'(cfg_i.upper_arm_length) * 30'(cfg_i.forearm_length)};
  end

  // Planar reach and full reach roots.
  ikn_sqrt u_sqrt_r2 (.clk_i(clk_i), .rad_i(34'(job_i.r2)), .root_o(rt_r2));
  ikn_sqrt u_sqrt_m2 (.clk_i(clk_i), .rad_i(job_i.m2),      .root_o(rt_m2));

  always_ff @(posedge clk_i) begin
    job_q[0] <= job_i;
    for (int j = 1; j < SL; j++) begin
      job_q[j] <= job_q[j-1];
    end
  end
  assign j1 = job_q[SL-1];

  // Numerators and denominators of both cosine ratios.
  assign prod_m = 32'(cfg_i.upper_arm_length) * 32'(rt_m2);

  always_comb begin
    geo_d.rejected = j1.rejected;
    geo_d.on_axis  = j1.on_axis;
    geo_d.x        = j1.x;
    geo_d.y        = j1.y;
    geo_d.w        = j1.w;
    geo_d.reach    = $signed({1'b0, rt_r2}) - 18'(ikn_pkg::ONE_CM);
    geo_d.tilt     = j1.tilt;
    geo_d.rotate   = j1.rotate;
    geo_d.grip     = j1.grip;
  end

  // The geometry waits beside the ratio registers and the whole divider.
  always_ff @(posedge clk_i) begin
    num_a_q  <= $signed({5'd0, d2sq_q}) - $signed({5'd0, d3sq_q}) + $signed({1'b0, j1.m2});
    num_b_q  <= $signed({5'd0, d2sq_q}) + $signed({5'd0, d3sq_q}) - $signed({1'b0, j1.m2});
    den_a_q  <= {prod_m, 1'b0};
    den_b_q  <= {1'b0, d2d3_q, 1'b0};
    geo_q[0] <= geo_d;
    for (int j = 1; j <= DL; j++) begin
      geo_q[j] <= geo_q[j-1];
    end
  end

  ikn_div u_div_a (
    .clk_i(clk_i), .num_i(num_a_q), .den_i(den_a_q),
    .q_o(q_a), .neg_o(neg_a), .sat_o(sat_a)
  );
  ikn_div u_div_b (
    .clk_i(clk_i), .num_i(num_b_q), .den_i(den_b_q),
    .q_o(q_b), .neg_o(neg_b), .sat_o(sat_b)
  );

  assign g3 = geo_q[DL];

  // Signed cosines and their squares.
  always_comb begin
    cos_d.geo   = g3;
    cos_d.sat_a = sat_a;
    cos_d.neg_a = neg_a;
    cos_d.sat_b = sat_b;
    cos_d.neg_b = neg_b;
    cos_d.c_a   = neg_a ? -$signed({1'b0, q_a}) : $signed({1'b0, q_a});
    cos_d.c_b   = neg_b ? -$signed({1'b0, q_b}) : $signed({1'b0, q_b});
  end

  // The cosines wait beside the square register and the whole root unit.
  always_ff @(posedge clk_i) begin
    qsq_a_q  <= 28'(q_a) * 28'(q_a);
    qsq_b_q  <= 28'(q_b) * 28'(q_b);
    cos_q[0] <= cos_d;
    for (int j = 1; j <= SL; j++) begin
      cos_q[j] <= cos_q[j-1];
    end
  end

  // Sines from one minus cosine squared.
  ikn_sqrt u_sqrt_a (
    .clk_i(clk_i), .rad_i(34'(ikn_pkg::COS_SQ) - 34'(qsq_a_q)), .root_o(s_a)
  );
  ikn_sqrt u_sqrt_b (
    .clk_i(clk_i), .rad_i(34'(ikn_pkg::COS_SQ) - 34'(qsq_b_q)), .root_o(s_b)
  );

  assign c5 = cos_q[SL];

  // Four angles resolved side by side.
  ikn_cordic u_cor_base (
    .clk_i(clk_i), .y_i(18'(c5.geo.y)), .x_i(18'(c5.geo.x)), .ang_o(ang_base)
  );
  ikn_cordic u_cor_wr (
    .clk_i(clk_i), .y_i(c5.geo.w), .x_i(c5.geo.reach), .ang_o(ang_wr)
  );
  ikn_cordic u_cor_a (
    .clk_i(clk_i), .y_i($signed({1'b0, s_a})), .x_i(18'(c5.c_a)), .ang_o(ang_a)
  );
  ikn_cordic u_cor_b (
    .clk_i(clk_i), .y_i($signed({1'b0, s_b})), .x_i(18'(c5.c_b)), .ang_o(ang_b)
  );

  always_comb begin
    fin_d.rejected = c5.geo.rejected;
    fin_d.on_axis  = c5.geo.on_axis;
    fin_d.tilt     = c5.geo.tilt;
    fin_d.rotate   = c5.geo.rotate;
    fin_d.grip     = c5.geo.grip;
    fin_d.sat_a    = c5.sat_a;
    fin_d.neg_a    = c5.neg_a;
    fin_d.sat_b    = c5.sat_b;
    fin_d.neg_b    = c5.neg_b;
  end

  always_ff @(posedge clk_i) begin
    fin_q[0] <= fin_d;
    for (int j = 1; j < CL; j++) begin
      fin_q[j] <= fin_q[j-1];
    end
  end

  assign f6 = fin_q[CL-1];

  // Joint angles, special cases and saturation.
  always_comb begin
    acos_a = f6.sat_a ? (f6.neg_a ? 16'(ikn_pkg::Q_PI) : 16'sd0) : ang_a;
    acos_b = f6.sat_b ? (f6.neg_b ? 16'(ikn_pkg::Q_PI) : 16'sd0) : ang_b;
    th1 = 20'(ikn_pkg::Q_HALF_PI) - 20'(ang_wr) - 20'(acos_a);
    th2 = 20'(ikn_pkg::Q_PI) - 20'(acos_b);
    th3 = 20'(ikn_pkg::Q_PI) - th1 - th2 + 20'(f6.tilt);
    res_d.rejected = 1'b0;
    res_d.rotate_out = f6.rotate;
    res_d.grip_out   = f6.grip;
    if (f6.rejected) begin
      res_d = '0;
      res_d.rejected = 1'b1;
    end else if (f6.on_axis) begin
      res_d.base_angle     = 16'sd0;
      res_d.shoulder_angle = 16'sd0;
      res_d.elbow_angle    = 16'sd0;
      res_d.wrist_angle    = f6.tilt;
    end else begin
      res_d.base_angle     = ang_base;
      res_d.shoulder_angle = ikn_pkg::sat16(th1);
      res_d.elbow_angle    = ikn_pkg::sat16(th2);
      res_d.wrist_angle    = ikn_pkg::sat16(th3);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
